// ===== hw/rtl/adsr_env_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_env_pkg
// Shared types, constants and the raised-cosine attack table of the
// multi-voice envelope generator.
// ----------------------------------------------------------------------------
package adsr_env_pkg;

  // Sizes
  localparam int VOICES          = 16;
  localparam int VOICE_BITS      = 4;
  localparam int LEVEL_BITS      = 16;
  localparam int PHASE_BITS      = 24;
  localparam int FACTOR_BITS     = 16;
  localparam int COS_TABLE_DEPTH = 256;    // power of two
  localparam int ROM_ADDR_BITS   = $clog2(COS_TABLE_DEPTH);
  localparam int ROM_SHIFT       = 31 - LEVEL_BITS;
  localparam int CFG_DATA_BITS   = PHASE_BITS;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  // Q2.30 constants for the table build
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Item kinds carried on tuser
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  // Envelope stage of a voice
  typedef enum logic [1:0] {
    ST_ATTACK  = 2'd0,
    ST_DECAY   = 2'd1,
    ST_RELEASE = 2'd2
  } stage_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ATTACK_STEP    = 2'd0,
    REG_DECAY_FACTOR   = 2'd1,
    REG_SUSTAIN_LEVEL  = 2'd2,
    REG_RELEASE_FACTOR = 2'd3
  } reg_e;

  typedef struct packed {
    logic [PHASE_BITS-1:0]  attack_step;
    logic [FACTOR_BITS-1:0] decay_factor;
    logic [LEVEL_BITS-1:0]  sustain_level;
    logic [FACTOR_BITS-1:0] release_factor;
  } cfg_t;

  // One entry of the voice memory
  typedef struct packed {
    stage_e                stage;
    logic [PHASE_BITS-1:0] phase;
    logic [LEVEL_BITS-1:0] excess;
    logic [LEVEL_BITS-1:0] rel_level;
    logic [LEVEL_BITS-1:0] last_level;
  } voice_state_t;

  localparam voice_state_t STATE_RESET = '{stage: ST_RELEASE, default: '0};

  // One result item
  typedef struct packed {
    logic [VOICE_BITS-1:0] voice;
    logic [LEVEL_BITS-1:0] level;
  } out_item_t;

  typedef logic [LEVEL_BITS-1:0] cos_rom_t [COS_TABLE_DEPTH];

  // Raised-cosine table: round(2^LEVEL_BITS * (1 - cos(pi*i/D)) / 2).
  // cos in Q2.30 by an eleven-term Taylor series on an angle folded into
  // [0, pi/2], every step truncated. Evaluated at elaboration only.
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t    rom;
    logic [63:0] m;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] q;
    longint      acc;
    longint      v;
    logic        neg;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      m   = 64'(i);
      neg = 1'b0;
      if (2 * i > COS_TABLE_DEPTH) begin
        m   = 64'(COS_TABLE_DEPTH - i);
        neg = 1'b1;
      end
      theta = (PI_Q30 * m) / 64'(COS_TABLE_DEPTH);
      x2    = (theta * theta) >> 30;
      term  = ONE_Q30;
      acc   = longint'(ONE_Q30);
      for (int k = 1; k <= 10; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        if (k[0]) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (neg) begin
        acc = -acc;
      end
      v = longint'(ONE_Q30) - acc;
      if (v < 0) begin
        v = 0;
      end
      q = (64'(v) + (64'd1 << (ROM_SHIFT - 1))) >> ROM_SHIFT;
      rom[i] = (q > 64'(LEVEL_MAX)) ? LEVEL_MAX : q[LEVEL_BITS-1:0];
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ===== hw/rtl/adsr_env_voice_mem.sv =====
// ----------------------------------------------------------------------------
// adsr_env_voice_mem
// Per-voice state memory: one write and one registered read port. Entries
// never written since reset read as the released, silent state.
// ----------------------------------------------------------------------------
module adsr_env_voice_mem (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [adsr_env_pkg::VOICE_BITS-1:0]  rd_addr_i,
  output adsr_env_pkg::voice_state_t           rd_data_o,
  input  logic                                 wr_en_i,
  input  logic [adsr_env_pkg::VOICE_BITS-1:0]  wr_addr_i,
  input  adsr_env_pkg::voice_state_t           wr_data_i
);

  adsr_env_pkg::voice_state_t            mem_q [adsr_env_pkg::VOICES];
  adsr_env_pkg::voice_state_t            rdata_q;
  logic [adsr_env_pkg::VOICES-1:0]       valid_q;
  logic                                  rvalid_q;

  // Storage array and read register
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Written-since-reset flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : adsr_env_pkg::STATE_RESET;

endmodule

// ===== hw/rtl/adsr_env_update.sv =====
// ----------------------------------------------------------------------------
// adsr_env_update
// Next-state and output level of one voice for a tick, press or release.
// ----------------------------------------------------------------------------
module adsr_env_update (
  input  adsr_env_pkg::op_e                     op_i,
  input  adsr_env_pkg::cfg_t                    cfg_i,
  input  adsr_env_pkg::voice_state_t            cur_i,
  output adsr_env_pkg::voice_state_t            nxt_o,
  output logic                                  wr_en_o,
  output logic                                  result_o,
  output logic [adsr_env_pkg::LEVEL_BITS-1:0]   level_o
);

  localparam int LB = adsr_env_pkg::LEVEL_BITS;
  localparam int PB = adsr_env_pkg::PHASE_BITS;
  localparam int FB = adsr_env_pkg::FACTOR_BITS;
  localparam int AB = adsr_env_pkg::ROM_ADDR_BITS;

  logic [PB:0]      phase_sum;
  logic [LB:0]      decay_sum;
  logic [LB+FB-1:0] decay_prod;
  logic [LB+FB-1:0] rel_prod;
  logic [LB-1:0]    rom_level;
  logic [LB-1:0]    lvl;

  // Datapath: phase step, sustain sum, the two scalings, table read
  assign phase_sum  = {1'b0, cur_i.phase} + {1'b0, cfg_i.attack_step};
  assign decay_sum  = {1'b0, cfg_i.sustain_level} + {1'b0, cur_i.excess};
  assign decay_prod = {{FB{1'b0}}, cur_i.excess} * {{LB{1'b0}}, cfg_i.decay_factor};
  assign rel_prod   = {{FB{1'b0}}, cur_i.rel_level} * {{LB{1'b0}}, cfg_i.release_factor};
  assign rom_level  = adsr_env_pkg::COS_ROM[cur_i.phase[PB-1 -: AB]];

  always_comb begin
    nxt_o    = cur_i;
    wr_en_o  = 1'b0;
    result_o = 1'b0;
    lvl      = '0;
    case (op_i)
      adsr_env_pkg::OP_PRESS: begin
        nxt_o   = '{stage: adsr_env_pkg::ST_ATTACK, default: '0};
        wr_en_o = 1'b1;
      end
      adsr_env_pkg::OP_RELEASE: begin
        nxt_o.stage     = adsr_env_pkg::ST_RELEASE;
        nxt_o.rel_level = cur_i.last_level;
        wr_en_o         = 1'b1;
      end
      adsr_env_pkg::OP_TICK: begin
        wr_en_o  = 1'b1;
        result_o = 1'b1;
        case (cur_i.stage)
          adsr_env_pkg::ST_ATTACK: begin
            lvl = rom_level;
            if (phase_sum[PB]) begin
              // phase wrapped: decay starts from full level
              nxt_o.stage  = adsr_env_pkg::ST_DECAY;
              nxt_o.phase  = '0;
              nxt_o.excess = adsr_env_pkg::LEVEL_MAX - cfg_i.sustain_level;
            end else begin
              nxt_o.phase = phase_sum[PB-1:0];
            end
          end
          adsr_env_pkg::ST_DECAY: begin
            lvl          = decay_sum[LB] ? adsr_env_pkg::LEVEL_MAX : decay_sum[LB-1:0];
            nxt_o.excess = decay_prod[LB+FB-1:FB];
          end
          default: begin
            // release, and the unused stage code
            lvl             = cur_i.rel_level;
            nxt_o.rel_level = rel_prod[LB+FB-1:FB];
          end
        endcase
        nxt_o.last_level = lvl;
      end
      default: begin
        // unused code: no change, no item out
      end
    endcase
  end

  assign level_o = lvl;

endmodule

// ===== hw/rtl/adsr_env_out_buf.sv =====
// ----------------------------------------------------------------------------
// adsr_env_out_buf
// Output register with a skid entry; ready toward the pipeline is registered.
// ----------------------------------------------------------------------------
module adsr_env_out_buf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  adsr_env_pkg::out_item_t  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output adsr_env_pkg::out_item_t  out_data_o
);

  logic                    out_v_q;
  logic                    skid_v_q;
  adsr_env_pkg::out_item_t out_q;
  adsr_env_pkg::out_item_t skid_q;
  logic                    in_fire;
  logic                    out_free;

  assign in_ready_o = !skid_v_q;
  assign in_fire    = in_valid_i && !skid_v_q;
  assign out_free   = !out_v_q || out_ready_i;

  // Occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= in_data_i;
      end
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/adsr_envelope_generator.sv =====
// Path: a tick's voice state is read from memory when the tick is accepted,
//   and its level enters the output buffer when the update stage moves on.
// Throughput: one item per cycle while the output buffer has room, set by the
//   single read-modify-write pass over the voice memory, with forwarding of the last write.
// Reset: every voice reads as released at level zero (per-entry valid flags,
//   no clearing pass); configuration registers return to their defaults.
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Multi-voice ADSR envelope generator on a shared voice state memory.
// ----------------------------------------------------------------------------
module adsr_envelope_generator (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration writes
  input  logic                                    cfg_we_i,
  input  logic [1:0]                              cfg_index_i,
  input  logic [adsr_env_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // input items
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  logic [7:0]                              s_axis_tdata_i,  // [3:0] voice
  input  logic [1:0]                              s_axis_tuser_i,  // [1:0] operation
  // result items
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [23:0]                             m_axis_tdata_o   // [15:0] level,
                                                                   // [19:16] voice_out
);

  localparam int VB = adsr_env_pkg::VOICE_BITS;

  adsr_env_pkg::cfg_t         cfg_q;
  logic                       s1_valid_q;
  adsr_env_pkg::op_e          s1_op_q;
  logic [VB-1:0]              s1_voice_q;
  logic                       fwd_valid_q;
  logic [VB-1:0]              fwd_voice_q;
  adsr_env_pkg::voice_state_t fwd_state_q;

  adsr_env_pkg::voice_state_t mem_rdata;
  adsr_env_pkg::voice_state_t cur_state;
  adsr_env_pkg::voice_state_t nxt_state;
  logic                       upd_wr;
  logic                       upd_result;
  logic [adsr_env_pkg::LEVEL_BITS-1:0] upd_level;
  logic                       buf_ready;
  logic                       s1_fire;
  logic                       in_accept;
  logic                       mem_wr;
  adsr_env_pkg::out_item_t    res_item;
  adsr_env_pkg::out_item_t    out_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step    <= 24'd69905;
      cfg_q.decay_factor   <= 16'd65509;
      cfg_q.sustain_level  <= 16'd65535;
      cfg_q.release_factor <= 16'd65522;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        adsr_env_pkg::REG_ATTACK_STEP:    cfg_q.attack_step    <= cfg_data_i;
        adsr_env_pkg::REG_DECAY_FACTOR:   cfg_q.decay_factor   <= cfg_data_i[15:0];
        adsr_env_pkg::REG_SUSTAIN_LEVEL:  cfg_q.sustain_level  <= cfg_data_i[15:0];
        adsr_env_pkg::REG_RELEASE_FACTOR: cfg_q.release_factor <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: the update stage moves on unless its result finds the buffer full
  assign s1_fire         = s1_valid_q && (!upd_result || buf_ready);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign mem_wr          = s1_fire && upd_wr;

  // Update stage item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= adsr_env_pkg::op_e'(s_axis_tuser_i);
      s1_voice_q <= s_axis_tdata_i[VB-1:0];
    end
  end

  // Last write, forwarded to a read that raced it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (mem_wr) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      fwd_voice_q <= s1_voice_q;
      fwd_state_q <= nxt_state;
    end
  end

  adsr_env_voice_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (s_axis_tdata_i[VB-1:0]),
    .rd_data_o (mem_rdata),
    .wr_en_i   (mem_wr),
    .wr_addr_i (s1_voice_q),
    .wr_data_i (nxt_state)
  );

  assign cur_state = (fwd_valid_q && (fwd_voice_q == s1_voice_q)) ? fwd_state_q : mem_rdata;

  adsr_env_update u_update (
    .op_i     (s1_op_q),
    .cfg_i    (cfg_q),
    .cur_i    (cur_state),
    .nxt_o    (nxt_state),
    .wr_en_o  (upd_wr),
    .result_o (upd_result),
    .level_o  (upd_level)
  );

  assign res_item.voice = s1_voice_q;
  assign res_item.level = upd_level;

  adsr_env_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q && upd_result),
    .in_ready_o  (buf_ready),
    .in_data_i   (res_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_item)
  );

  assign m_axis_tdata_o = {4'b0000, out_item.voice, out_item.level};

  // Checks
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_voice_q)))
    else $error("update stage lost a stalled item");

  a_decay_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_op_q == adsr_env_pkg::OP_TICK)
      && (cur_state.stage == adsr_env_pkg::ST_DECAY))
    |-> (upd_level >= cfg_q.sustain_level))
    else $error("decay level fell below sustain");

  a_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr && in_accept && (s1_voice_q == s_axis_tdata_i[VB-1:0]))
    |=> (fwd_valid_q && (fwd_voice_q == s1_voice_q)))
    else $error("back-to-back access to one voice not forwarded");

endmodule
